// ----- rtl/gbmf_pkg.sv -----
// Package for the gyro bias and motion fusion unit: shared types, register
// codes, reset values, sign tables and arithmetic helpers.
// No dependencies.
package gbmf_pkg;

   localparam int NUM_IMUS_DEFAULT = 6;
   localparam int CSR_ADDR_W       = 5;
   localparam int CSR_DATA_W       = 32;

   localparam logic [16:0] STAT_MAX     = 17'd100000;
   localparam logic [15:0] HOLD_RESET   = 16'd1000;

   localparam logic [14:0] DC_THRESH_RESET  = 15'd250;
   localparam logic [23:0] AC_THRESH_RESET  = 24'd38400;
   localparam logic [23:0] BLANK_RESET      = 24'd25600;
   localparam logic [3:0]  SHIFT_RESET      = 4'd10;
   localparam logic [15:0] MOVING_HOLD_RESET = 16'd1000;
   localparam logic [16:0] AC_ENABLE_RESET  = 17'd20000;
   localparam logic [16:0] FUSE_ENABLE_RESET = 17'd1000;

   // per-IMU routing, bit n belongs to IMU n
   localparam logic [7:0] X_FEEDS_PITCH = 8'b0000_0011;
   localparam logic [7:0] PITCH_NEG     = 8'b0010_1001;
   localparam logic [7:0] ROLL_NEG      = 8'b0001_0101;

   typedef enum logic [2:0] {
      REG_DC_THRESH   = 3'd0,
      REG_AC_THRESH   = 3'd1,
      REG_BLANK       = 3'd2,
      REG_BIAS_SHIFT  = 3'd3,
      REG_MOVING_HOLD = 3'd4,
      REG_AC_ENABLE   = 3'd5,
      REG_FUSE_ENABLE = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic [14:0] dc_motion_threshold;
      logic [23:0] ac_motion_threshold;
      logic [23:0] blanking_threshold;
      logic [3:0]  bias_filter_shift;
      logic [15:0] moving_hold;
      logic [16:0] ac_enable_count;
      logic [16:0] fuse_enable_count;
   } cfg_type;

   typedef struct packed {
      logic [2:0]         imu_index;
      logic signed [15:0] gyro_x;
      logic signed [15:0] gyro_y;
      logic signed [15:0] gyro_z;
   } item_type;

   typedef struct packed {
      logic signed [24:0] corrected_x;
      logic signed [24:0] corrected_y;
      logic signed [24:0] corrected_z;
      logic               moving;
      logic               frame_end;
      logic               fused_valid;
      logic signed [27:0] pitch_sum;
      logic signed [27:0] roll_sum;
      logic signed [27:0] yaw_sum;
   } core_result_type;

   function automatic logic [15:0] abs_raw(input logic signed [15:0] v);
      return v[15] ? 16'(-v) : 16'(v);
   endfunction

   function automatic logic [24:0] abs_corr(input logic signed [25:0] v);
      return v[25] ? 25'(-v) : 25'(v);
   endfunction

   // floor(((raw << 15) + (2^s - 1) * old) / 2^s)
   function automatic logic signed [31:0] bias_next(input logic signed [15:0] raw,
                                                    input logic signed [31:0] old,
                                                    input logic [3:0] shift);
      logic signed [47:0] old_ext;
      logic signed [47:0] acc;
      old_ext = {{16{old[31]}}, old};
      acc = {{17{raw[15]}}, raw, 15'd0} + (old_ext <<< shift) - old_ext;
      return 32'(acc >>> shift);
   endfunction

   // divide toward zero by a constant through its rounded-up reciprocal at 2^31
   function automatic logic signed [24:0] fuse_scale(input logic signed [27:0] sum,
                                                     input logic [31:0] recip);
      logic [27:0] mag;
      logic [59:0] prod;
      logic [28:0] quot;
      mag  = sum[27] ? 28'(-sum) : 28'(sum);
      prod = 60'(mag) * 60'(recip);
      quot = prod[59:31];
      return sum[27] ? 25'(-quot) : 25'(quot);
   endfunction

endpackage

// ----- rtl/gbmf_csr.sv -----
// Configuration register bank on an APB-style port.
// Depends on gbmf_pkg for the register codes, reset values and cfg_type.
module gbmf_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [gbmf_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [gbmf_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [gbmf_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready,
   output gbmf_pkg::cfg_type                 cfg
);

   gbmf_pkg::cfg_type       cfg_ff;
   gbmf_pkg::cfg_type       cfg_in;
   gbmf_pkg::reg_index_type index;
   logic                    wr_en;

   assign index      = gbmf_pkg::reg_index_type'(csr_paddr[gbmf_pkg::CSR_ADDR_W-1:2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (index)
            gbmf_pkg::REG_DC_THRESH:   cfg_in.dc_motion_threshold = csr_pwdata[14:0];
            gbmf_pkg::REG_AC_THRESH:   cfg_in.ac_motion_threshold = csr_pwdata[23:0];
            gbmf_pkg::REG_BLANK:       cfg_in.blanking_threshold  = csr_pwdata[23:0];
            gbmf_pkg::REG_BIAS_SHIFT:  cfg_in.bias_filter_shift   = csr_pwdata[3:0];
            gbmf_pkg::REG_MOVING_HOLD: cfg_in.moving_hold         = csr_pwdata[15:0];
            gbmf_pkg::REG_AC_ENABLE:   cfg_in.ac_enable_count     = csr_pwdata[16:0];
            gbmf_pkg::REG_FUSE_ENABLE: cfg_in.fuse_enable_count   = csr_pwdata[16:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         gbmf_pkg::REG_DC_THRESH:   csr_prdata = 32'(cfg_ff.dc_motion_threshold);
         gbmf_pkg::REG_AC_THRESH:   csr_prdata = 32'(cfg_ff.ac_motion_threshold);
         gbmf_pkg::REG_BLANK:       csr_prdata = 32'(cfg_ff.blanking_threshold);
         gbmf_pkg::REG_BIAS_SHIFT:  csr_prdata = 32'(cfg_ff.bias_filter_shift);
         gbmf_pkg::REG_MOVING_HOLD: csr_prdata = 32'(cfg_ff.moving_hold);
         gbmf_pkg::REG_AC_ENABLE:   csr_prdata = 32'(cfg_ff.ac_enable_count);
         gbmf_pkg::REG_FUSE_ENABLE: csr_prdata = 32'(cfg_ff.fuse_enable_count);
         default:                   csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dc_motion_threshold <= gbmf_pkg::DC_THRESH_RESET;
         cfg_ff.ac_motion_threshold <= gbmf_pkg::AC_THRESH_RESET;
         cfg_ff.blanking_threshold  <= gbmf_pkg::BLANK_RESET;
         cfg_ff.bias_filter_shift   <= gbmf_pkg::SHIFT_RESET;
         cfg_ff.moving_hold         <= gbmf_pkg::MOVING_HOLD_RESET;
         cfg_ff.ac_enable_count     <= gbmf_pkg::AC_ENABLE_RESET;
         cfg_ff.fuse_enable_count   <= gbmf_pkg::FUSE_ENABLE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- rtl/gbmf_core.sv -----
// Bias correction, motion detection and fusion sums for one registered reading;
// holds the per-IMU bias, hold counter, stationary count and frame sums.
// Depends on gbmf_pkg.
module gbmf_core #(
   parameter int NUM_IMUS = gbmf_pkg::NUM_IMUS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  gbmf_pkg::cfg_type         cfg,
   input  gbmf_pkg::item_type        item,
   input  logic                      advance,
   output gbmf_pkg::core_result_type result
);

   localparam int IDX_W = (NUM_IMUS > 1) ? $clog2(NUM_IMUS) : 1;

   logic signed [31:0] bias_x_ff [NUM_IMUS];
   logic signed [31:0] bias_y_ff [NUM_IMUS];
   logic signed [31:0] bias_z_ff [NUM_IMUS];
   logic [15:0]        hold_ff, hold_in;
   logic [16:0]        stat_ff, stat_in, stat_inc;
   logic signed [27:0] pitch_ff, pitch_in, roll_ff, roll_in, yaw_ff, yaw_in;

   logic [IDX_W-1:0]   sel;
   logic signed [31:0] bx, by, bz;
   logic signed [25:0] cx, cy, cz;
   logic signed [25:0] x_term, y_term, z_term;
   logic signed [25:0] pitch_add, roll_add;
   logic signed [27:0] pitch_new, roll_new, yaw_new;
   logic               dc_hit, ac_hit, motion, still, frame_end, fuse_ok;
   logic               x_pitch, x_neg, y_neg;

   assign sel = item.imu_index[IDX_W-1:0];
   assign bx  = bias_x_ff[sel];
   assign by  = bias_y_ff[sel];
   assign bz  = bias_z_ff[sel];

   assign cx = {{2{item.gyro_x[15]}}, item.gyro_x, 8'd0} - {bx[31], bx[31:7]};
   assign cy = {{2{item.gyro_y[15]}}, item.gyro_y, 8'd0} - {by[31], by[31:7]};
   assign cz = {{2{item.gyro_z[15]}}, item.gyro_z, 8'd0} - {bz[31], bz[31:7]};

   assign dc_hit = (gbmf_pkg::abs_raw(item.gyro_x) > {1'b0, cfg.dc_motion_threshold})
                 | (gbmf_pkg::abs_raw(item.gyro_y) > {1'b0, cfg.dc_motion_threshold})
                 | (gbmf_pkg::abs_raw(item.gyro_z) > {1'b0, cfg.dc_motion_threshold});
   assign ac_hit = (gbmf_pkg::abs_corr(cx) > {1'b0, cfg.ac_motion_threshold})
                 | (gbmf_pkg::abs_corr(cy) > {1'b0, cfg.ac_motion_threshold})
                 | (gbmf_pkg::abs_corr(cz) > {1'b0, cfg.ac_motion_threshold});
   assign motion = dc_hit | ((stat_ff > cfg.ac_enable_count) & ac_hit);

   always_comb begin
      if (motion) begin
         hold_in = cfg.moving_hold;
      end else if (hold_ff != '0) begin
         hold_in = hold_ff - 16'd1;
      end else begin
         hold_in = hold_ff;
      end
   end

   assign still     = (hold_in == '0);
   assign stat_inc  = (still && stat_ff < gbmf_pkg::STAT_MAX) ? stat_ff + 17'd1 : stat_ff;
   assign frame_end = (item.imu_index == 3'(NUM_IMUS - 1));
   assign fuse_ok   = (stat_inc > cfg.fuse_enable_count);
   assign stat_in   = (frame_end && !fuse_ok && !still) ? '0 : stat_inc;

   assign x_pitch = gbmf_pkg::X_FEEDS_PITCH[item.imu_index];
   assign x_neg   = x_pitch ? gbmf_pkg::PITCH_NEG[item.imu_index]
                            : gbmf_pkg::ROLL_NEG[item.imu_index];
   assign y_neg   = x_pitch ? gbmf_pkg::ROLL_NEG[item.imu_index]
                            : gbmf_pkg::PITCH_NEG[item.imu_index];

   always_comb begin
      x_term = '0;
      y_term = '0;
      z_term = '0;
      if (gbmf_pkg::abs_corr(cx) > {1'b0, cfg.blanking_threshold}) begin
         x_term = x_neg ? -cx : cx;
      end
      if (gbmf_pkg::abs_corr(cy) > {1'b0, cfg.blanking_threshold}) begin
         y_term = y_neg ? -cy : cy;
      end
      if (gbmf_pkg::abs_corr(cz) > {1'b0, cfg.blanking_threshold}) begin
         z_term = cz;
      end
   end

   assign pitch_add = x_pitch ? x_term : y_term;
   assign roll_add  = x_pitch ? y_term : x_term;
   assign pitch_new = pitch_ff + 28'(pitch_add);
   assign roll_new  = roll_ff + 28'(roll_add);
   assign yaw_new   = yaw_ff + 28'(z_term);

   assign pitch_in = frame_end ? '0 : pitch_new;
   assign roll_in  = frame_end ? '0 : roll_new;
   assign yaw_in   = frame_end ? '0 : yaw_new;

   always_comb begin
      result.corrected_x = cx[24:0];
      result.corrected_y = cy[24:0];
      result.corrected_z = cz[24:0];
      result.moving      = !still;
      result.frame_end   = frame_end;
      result.fused_valid = frame_end & fuse_ok;
      result.pitch_sum   = frame_end ? pitch_new : '0;
      result.roll_sum    = frame_end ? roll_new : '0;
      result.yaw_sum     = frame_end ? yaw_new : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff  <= gbmf_pkg::HOLD_RESET;
         stat_ff  <= '0;
         pitch_ff <= '0;
         roll_ff  <= '0;
         yaw_ff   <= '0;
         for (int i = 0; i < NUM_IMUS; i++) begin
            bias_x_ff[i] <= '0;
            bias_y_ff[i] <= '0;
            bias_z_ff[i] <= '0;
         end
      end else if (advance) begin
         hold_ff  <= hold_in;
         stat_ff  <= stat_in;
         pitch_ff <= pitch_in;
         roll_ff  <= roll_in;
         yaw_ff   <= yaw_in;
         if (still) begin
            bias_x_ff[sel] <= gbmf_pkg::bias_next(item.gyro_x, bx, cfg.bias_filter_shift);
            bias_y_ff[sel] <= gbmf_pkg::bias_next(item.gyro_y, by, cfg.bias_filter_shift);
            bias_z_ff[sel] <= gbmf_pkg::bias_next(item.gyro_z, bz, cfg.bias_filter_shift);
         end
      end
   end

endmodule

// ----- rtl/gyro_bias_motion_fusion_unit.sv -----
// Top level of the gyro bias and motion fusion unit: input register, core,
// result register and fused-rate scaling stage. Depends on gbmf_pkg,
// gbmf_csr and gbmf_core.
//
//   channel  direction  handshake            payload
//   req_     in         req_valid/req_ready   imu_index, gyro_x/y/z
//   rsp_     out        rsp_valid/rsp_ready   corrected_x/y/z, moving, frame_end,
//                                             fused_valid, fused_pitch/roll/yaw
//   csr_     in/out     psel/penable/pready   APB-style register access
//
// One transaction per cycle sustained while rsp_ready stays high; a result is offered
// through three registers (input, core result, fused-rate divide).
// The bias, hold and stationary state update as a reading leaves the input register.
// Readings with an index at or above NUM_IMUS are taken and dropped.
// Each stage holds while the next is full; req_ready stays high whenever rsp_ready is.
// Synchronous reset empties the stages, presets core state and restores register defaults.
module gyro_bias_motion_fusion_unit #(
   parameter int NUM_IMUS = gbmf_pkg::NUM_IMUS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [2:0]                       req_imu_index,
   input  logic signed [15:0]               req_gyro_x,
   input  logic signed [15:0]               req_gyro_y,
   input  logic signed [15:0]               req_gyro_z,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic signed [24:0]               rsp_corrected_x,
   output logic signed [24:0]               rsp_corrected_y,
   output logic signed [24:0]               rsp_corrected_z,
   output logic                             rsp_moving,
   output logic                             rsp_frame_end,
   output logic                             rsp_fused_valid,
   output logic signed [24:0]               rsp_fused_pitch,
   output logic signed [24:0]               rsp_fused_roll,
   output logic signed [24:0]               rsp_fused_yaw,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [gbmf_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [gbmf_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [gbmf_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);

   localparam logic [31:0] FUSE_RECIP = 32'(((64'd1 << 31) + 64'(NUM_IMUS) - 64'd1)
                                            / 64'(NUM_IMUS));

   gbmf_pkg::cfg_type         cfg;
   gbmf_pkg::item_type        item_ff;
   gbmf_pkg::core_result_type core_result;
   gbmf_pkg::core_result_type mid_ff;
   logic                      s1_valid_ff, s1_valid_in;
   logic                      s2_valid_ff, s2_valid_in;
   logic                      s3_valid_ff, s3_valid_in;
   logic                      s2_adv, s3_adv, req_take, in_range;

   gbmf_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   gbmf_core #(
      .NUM_IMUS (NUM_IMUS)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .item    (item_ff),
      .advance (s2_adv),
      .result  (core_result)
   );

   assign s3_adv    = s2_valid_ff & (!s3_valid_ff | rsp_ready);
   assign s2_adv    = s1_valid_ff & (!s2_valid_ff | s3_adv);
   assign req_ready = !s1_valid_ff | s2_adv;
   assign req_take  = req_valid & req_ready;
   assign in_range  = (4'(req_imu_index) < 4'(NUM_IMUS));

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = in_range;
      end else if (s2_adv) begin
         s1_valid_in = 1'b0;
      end
      s2_valid_in = s2_adv | (s2_valid_ff & !s3_adv);
      s3_valid_in = s3_adv | (s3_valid_ff & !rsp_ready);
   end

   assign rsp_valid = s3_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff.imu_index <= req_imu_index;
         item_ff.gyro_x    <= req_gyro_x;
         item_ff.gyro_y    <= req_gyro_y;
         item_ff.gyro_z    <= req_gyro_z;
      end
      if (s2_adv) begin
         mid_ff <= core_result;
      end
      if (s3_adv) begin
         rsp_corrected_x <= mid_ff.corrected_x;
         rsp_corrected_y <= mid_ff.corrected_y;
         rsp_corrected_z <= mid_ff.corrected_z;
         rsp_moving      <= mid_ff.moving;
         rsp_frame_end   <= mid_ff.frame_end;
         rsp_fused_valid <= mid_ff.fused_valid;
         rsp_fused_pitch <= gbmf_pkg::fuse_scale(mid_ff.pitch_sum, FUSE_RECIP);
         rsp_fused_roll  <= gbmf_pkg::fuse_scale(mid_ff.roll_sum, FUSE_RECIP);
         rsp_fused_yaw   <= gbmf_pkg::fuse_scale(mid_ff.yaw_sum, FUSE_RECIP);
      end
   end

endmodule

// ----- rtl/gbmf_checker.sv -----
// Port-level checks for the gyro bias and motion fusion unit, bound to its top.
// Depends on gyro_bias_motion_fusion_unit.
module gbmf_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [24:0] rsp_corrected_x,
   input logic               rsp_frame_end,
   input logic               rsp_fused_valid,
   input logic signed [24:0] rsp_fused_pitch,
   input logic signed [24:0] rsp_fused_roll,
   input logic signed [24:0] rsp_fused_yaw
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_corrected_x)
                                  && $stable(rsp_frame_end))
      else $error("result transaction changed while stalled");

   a_fused_only_at_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_frame_end |-> !rsp_fused_valid && rsp_fused_pitch == '0
                                      && rsp_fused_roll == '0 && rsp_fused_yaw == '0)
      else $error("fused rates outside frame end");

   a_no_bubble_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("input stalled while output drains");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind gyro_bias_motion_fusion_unit gbmf_checker u_gbmf_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_corrected_x (rsp_corrected_x),
   .rsp_frame_end   (rsp_frame_end),
   .rsp_fused_valid (rsp_fused_valid),
   .rsp_fused_pitch (rsp_fused_pitch),
   .rsp_fused_roll  (rsp_fused_roll),
   .rsp_fused_yaw   (rsp_fused_yaw)
);
